// ----- hdl/wep_pkg.sv -----
// Shared types and constants for the wheel encoder period speed meter.
package wep_pkg;

  localparam int unsigned CHANNELS_DEF = 2;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam int unsigned CAP_W      = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TMO_W      = 16;
  localparam int unsigned NUM_W      = 40;
  localparam int unsigned ALPHA_W    = 9;
  localparam int unsigned SPEED_W    = 24;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned MS_SCALE_W = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  localparam logic [CAP_W-1:0]      MIN_PERIOD_RST = 32'd500;
  localparam logic [TMO_W-1:0]      TIMEOUT_RST    = 16'd100;
  localparam logic [NUM_W-1:0]      NUMERATOR_RST  = 40'd266240000;
  localparam logic [ALPHA_W-1:0]    ALPHA_RST      = 9'd77;
  localparam logic [ALPHA_W-1:0]    ALPHA_MAX      = 9'd256;
  localparam logic [SPEED_W-1:0]    SPEED_MAX      = 24'hFFFFFF;
  localparam logic [SPEED_W-1:0]    SEED_LIMIT     = 24'd2;
  localparam logic [MS_SCALE_W-1:0] US_PER_MS      = 10'd1000;

  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PERIOD = 3'd0,
    CFG_TIMEOUT    = 3'd1,
    CFG_NUMERATOR  = 3'd2,
    CFG_ALPHA      = 3'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_EDGE,
    OP_QUERY,
    OP_QUERY_BAD
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SEED,
    ST_MUL,
    ST_UPDATE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    op_e               op;
    logic              channel;
    logic [CAP_W-1:0]  capture_us;
    logic [TIME_W-1:0] time_ms;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [CAP_W-1:0]   min_period_us;
    logic [TMO_W-1:0]   timeout_ms;
    logic [NUM_W-1:0]   speed_numerator;
    logic [ALPHA_W-1:0] ema_alpha;
  } cfg_t;

endpackage

// ----- hdl/wep_front.sv -----
// Input stage: accepts transactions, classifies them and queues them for the back end.
module wep_front
  import wep_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic              channel_i,
  input  logic [CAP_W-1:0]  capture_us_i,
  input  logic [TIME_W-1:0] time_ms_i,
  output head_t             head_o,
  input  logic              pop_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  item_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] cnt_q, cnt_d;
  logic              ch_ok;
  logic              accept;
  logic              push;
  logic              pop;
  item_t             item;

  assign ch_ok      = (CHANNELS > 1) || (channel_i == 1'b0);
  assign in_ready_o = (cnt_q != CNT_QW'(QUEUE_DEPTH));
  assign accept     = in_valid_i && in_ready_o;
  // edges on a channel that does not exist are dropped here
  assign push       = accept && ((cmd_i == CMD_QUERY) || ch_ok);
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    item.channel    = channel_i;
    item.capture_us = capture_us_i;
    item.time_ms    = time_ms_i;
    if (cmd_i == CMD_EDGE) begin
      item.op = OP_EDGE;
    end else if (ch_ok) begin
      item.op = OP_QUERY;
    end else begin
      item.op = OP_QUERY_BAD;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

// ----- hdl/wep_div.sv -----
// Restoring divider, one quotient bit per cycle.
module wep_div
  import wep_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [CAP_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [CAP_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [CAP_W-1:0]  den_q;
  logic [CAP_W:0]    trial;
  logic [CAP_W:0]    diff;
  logic              ge;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});
  assign rem_d = ge ? diff[CAP_W-1:0] : trial[CAP_W-1:0];
  assign quo_d = {quo_q[NUM_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_W'(NUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hdl/wep_back.sv -----
// Execution stage: per-channel state, speed computation, filter and result register.
module wep_back
  import wep_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  head_t              head_i,
  output logic               pop_o,
  input  cfg_t               cfg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               result_channel_o,
  output logic [SPEED_W-1:0] speed_q8_o,
  output logic [CNT_W-1:0]   edge_count_o
);

  localparam int unsigned IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PROD_W = ALPHA_W + SPEED_W;
  localparam int unsigned TUS_W  = TMO_W + MS_SCALE_W;

  state_e state_q, state_d;

  logic [CAP_W-1:0]   last_capture_q [CHANNELS];
  logic               have_prev_q    [CHANNELS];
  logic [CAP_W-1:0]   last_period_q  [CHANNELS];
  logic [CNT_W-1:0]   valid_edges_q  [CHANNELS];
  logic [TIME_W-1:0]  last_edge_ms_q [CHANNELS];
  logic [CNT_W-1:0]   seen_edges_q   [CHANNELS];
  logic [SPEED_W-1:0] filt_q         [CHANNELS];

  item_t              cur_q;
  logic [SPEED_W-1:0] v_q;
  logic [SPEED_W-1:0] diff_q;
  logic               up_q;
  logic [PROD_W-1:0]  prod_q;

  logic               out_valid_q;
  logic               out_ch_q;
  logic [SPEED_W-1:0] out_speed_q;
  logic [CNT_W-1:0]   out_count_q;

  logic [IDX_W-1:0]   idx;
  logic               bad;
  logic               new_edges;
  logic [TUS_W-1:0]   tmo_us;
  logic               per_ok;
  logic [TIME_W-1:0]  elapsed;
  logic               timed_out;
  logic [CAP_W-1:0]   edge_per;
  logic [SPEED_W-1:0] f_cur;
  logic               seed;
  logic [SPEED_W-1:0] step;
  logic [SPEED_W-1:0] v_sat;
  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   quotient;
  logic               out_load;
  logic               edge_go;

  assign idx       = (state_q == ST_IDLE) ? IDX_W'(head_i.item.channel) : IDX_W'(cur_q.channel);
  assign bad       = (cur_q.op == OP_QUERY_BAD);
  assign new_edges = (valid_edges_q[idx] != seen_edges_q[idx]);
  assign tmo_us    = TUS_W'(cfg_i.timeout_ms) * TUS_W'(US_PER_MS);
  assign per_ok    = (last_period_q[idx] != '0) && (last_period_q[idx] < CAP_W'(tmo_us));
  assign elapsed   = cur_q.time_ms - last_edge_ms_q[idx];
  assign timed_out = (elapsed > TIME_W'(cfg_i.timeout_ms));
  assign edge_per  = head_i.item.capture_us - last_capture_q[idx];
  assign f_cur     = filt_q[idx];
  assign seed      = (f_cur <= SEED_LIMIT);
  assign step      = prod_q[SPEED_W+7:8];
  assign v_sat     = (|quotient[NUM_W-1:SPEED_W]) ? SPEED_MAX : quotient[SPEED_W-1:0];
  assign edge_go   = pop_o && (head_i.item.op == OP_EDGE);

  wep_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cfg_i.speed_numerator),
    .divisor_i  (last_period_q[idx]),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid && (head_i.item.op != OP_EDGE)) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!bad && new_edges && per_ok) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_SEED;
        end
      end
      ST_SEED: begin
        state_d = seed ? ST_RESULT : ST_MUL;
      end
      ST_MUL:    state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_RESULT;
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = (state_q == ST_IDLE) && head_i.valid;
    div_start = (state_q == ST_CHECK) && !bad && new_edges && per_ok;
    out_load  = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int i = 0; i < CHANNELS; i++) begin
        last_capture_q[i] <= '0;
        have_prev_q[i]    <= 1'b0;
        last_period_q[i]  <= '0;
        valid_edges_q[i]  <= '0;
        last_edge_ms_q[i] <= '0;
        seen_edges_q[i]   <= '0;
        filt_q[i]         <= '0;
      end
    end else begin
      state_q <= state_d;
      if (edge_go) begin
        if (have_prev_q[idx]) begin
          if (edge_per >= cfg_i.min_period_us) begin
            last_period_q[idx]  <= edge_per;
            valid_edges_q[idx]  <= valid_edges_q[idx] + 1'b1;
            last_capture_q[idx] <= head_i.item.capture_us;
            last_edge_ms_q[idx] <= head_i.item.time_ms;
          end
        end else begin
          have_prev_q[idx]    <= 1'b1;
          last_capture_q[idx] <= head_i.item.capture_us;
          last_edge_ms_q[idx] <= head_i.item.time_ms;
        end
      end
      if ((state_q == ST_CHECK) && !bad) begin
        if (new_edges) begin
          seen_edges_q[idx] <= valid_edges_q[idx];
        end else if (timed_out) begin
          filt_q[idx] <= '0;
        end
      end
      if ((state_q == ST_SEED) && seed) begin
        filt_q[idx] <= v_q;
      end
      if (state_q == ST_UPDATE) begin
        filt_q[idx] <= up_q ? f_cur + step : f_cur - step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i.item;
    end
    if ((state_q == ST_DIV) && div_done) begin
      v_q <= v_sat;
    end
    if (state_q == ST_SEED) begin
      up_q   <= (v_q >= f_cur);
      diff_q <= (v_q >= f_cur) ? v_q - f_cur : f_cur - v_q;
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(cfg_i.ema_alpha) * PROD_W'(diff_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q    <= cur_q.channel;
      out_speed_q <= bad ? '0 : filt_q[idx];
      out_count_q <= bad ? '0 : valid_edges_q[idx];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_channel_o = out_ch_q;
  assign speed_q8_o       = out_speed_q;
  assign edge_count_o     = out_count_q;

endmodule

// ----- hdl/wheel_encoder_period_speed_core.sv -----
// Top level of the two-channel wheel encoder period speed meter.
// Edge captures and speed queries enter through a two-entry queue and are executed
// one at a time. An edge capture updates its channel state as it is popped. A query
// with new edges and a usable period runs a serial divide of speed_numerator by the
// period, one quotient bit per cycle, then the filter step (seed check, multiply,
// update, with multiply and update skipped when the filter seeds from the new speed)
// and the result load; other queries skip the divide and filter step. The
// divider sets the sustained query rate. Input transactions keep being accepted while
// the queue has room; a finished result waits in the output register, and the next
// result load, and with it the execution stage, waits until that result is taken.
module wheel_encoder_period_speed_core
  import wep_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic                  channel_i,
  input  logic [CAP_W-1:0]      capture_us_i,
  input  logic [TIME_W-1:0]     time_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  result_channel_o,
  output logic [SPEED_W-1:0]    speed_q8_o,
  output logic [CNT_W-1:0]      edge_count_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t               cfg_q;
  head_t              head;
  logic               pop;
  logic [ALPHA_W-1:0] alpha_wr;

  assign cfg_ready_o = 1'b1;
  assign alpha_wr    = (cfg_data_i[ALPHA_W-1:0] > ALPHA_MAX) ? ALPHA_MAX
                                                             : cfg_data_i[ALPHA_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_period_us   <= MIN_PERIOD_RST;
      cfg_q.timeout_ms      <= TIMEOUT_RST;
      cfg_q.speed_numerator <= NUMERATOR_RST;
      cfg_q.ema_alpha       <= ALPHA_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_PERIOD: cfg_q.min_period_us   <= cfg_data_i[CAP_W-1:0];
        CFG_TIMEOUT:    cfg_q.timeout_ms      <= cfg_data_i[TMO_W-1:0];
        CFG_NUMERATOR:  cfg_q.speed_numerator <= cfg_data_i[NUM_W-1:0];
        CFG_ALPHA:      cfg_q.ema_alpha       <= alpha_wr;
        default: ;
      endcase
    end
  end

  wep_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .channel_i    (channel_i),
    .capture_us_i (capture_us_i),
    .time_ms_i    (time_ms_i),
    .head_o       (head),
    .pop_i        (pop)
  );

  wep_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .pop_o            (pop),
    .cfg_i            (cfg_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_channel_o (result_channel_o),
    .speed_q8_o       (speed_q8_o),
    .edge_count_o     (edge_count_o)
  );

endmodule
